// ----- hw/rtl/rbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_HEAD = 3'd0,
    FN_PUSH_TAIL = 3'd1,
    FN_POP_HEAD  = 3'd2,
    FN_POP_TAIL  = 3'd3,
    FN_PEEK_HEAD = 3'd4,
    FN_PEEK_TAIL = 3'd5,
    FN_CONTAINS  = 3'd6,
    FN_CLEAR     = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rbd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ring_buffer_deque.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of words in a ring of DEPTH slots (DEPTH-1 usable).
//
// One transaction on the in_ channel carries an operation (in_func) and a
// word (in_value); each gives exactly one transaction on the out_ channel
// with the popped or peeked word, a found flag, a status and the entry count.
// The slots live in one RAM with a registered read.
// Push, clear and refused operations go straight to the finish state; pop
// and peek first do one RAM read, and a contains does one RAM read per entry
// compared, stopping at the first match or after all n entries. One item is
// worked on at a time; a new item is taken as soon as the previous result
// has entered the output register, even while it waits under out_stall.
// Reset empties the ring (head 0, tail 1); slot contents stay undefined.
// While out_stall is high the result holds in the output register and a
// finished result behind it waits, stalling the input.
// ----------------------------------------------------------------------------
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic [DATA_W-1:0]   in_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [DATA_W-1:0]   out_data,
  output logic                     out_found,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [COUNT_W-1:0]  out_count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_FIN
  } state_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    ring_prev = (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] h,
                                                  input logic [PTR_W-1:0] t);
    logic [PTR_W:0] c;
    if (t > h) begin
      c = {1'b0, t} - {1'b0, h} - 1'b1;
    end else begin
      c = DEPTH_EXT - {1'b0, h} + {1'b0, t} - 1'b1;
    end
    ring_count = c[PTR_W-1:0];
  endfunction

  state_t               state_r;
  logic [PTR_W-1:0]     head_r;
  logic [PTR_W-1:0]     tail_r;
  logic [WORD_BITS-1:0] word_r;
  logic [PTR_W-1:0]     scan_p_r;
  logic [PTR_W-1:0]     left_r;
  logic [WORD_BITS-1:0] res_data_r;
  logic                 res_found_r;
  status_t              res_status_r;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_found_r;
  status_t              out_status_r;
  logic [COUNT_W-1:0]   out_count_r;

  state_t               state_nxt;
  logic [PTR_W-1:0]     head_nxt;
  logic [PTR_W-1:0]     tail_nxt;
  status_t              status_nxt;

  func_t                in_fn;
  logic [WORD_BITS-1:0] in_word;
  logic                 acc;
  logic [PTR_W-1:0]     n_cur;
  logic                 is_full;
  logic                 ring_empty;
  logic                 out_free;
  logic                 out_load;
  logic [CNT_W-1:0]     cnt_ext;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign in_fn      = func_t'(in_func);
  assign in_word    = in_value[WORD_BITS-1:0];
  assign in_stall   = (state_r != S_IDLE);
  assign acc        = in_valid && (state_r == S_IDLE);
  assign n_cur      = ring_count(head_r, tail_r);
  assign is_full    = (n_cur == LAST_SLOT);
  assign ring_empty = (n_cur == '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign out_load   = (state_r == S_FIN) && out_free;
  assign cnt_ext    = CNT_W'(n_cur);

  // ram write on accepted push unless full, read on every acceptance and during a contains scan
  always_comb begin
    ram_we    = acc && !is_full &&
                ((in_fn == FN_PUSH_HEAD) || (in_fn == FN_PUSH_TAIL));
    ram_waddr = (in_fn == FN_PUSH_HEAD) ? head_r : tail_r;
    ram_re    = acc || (state_r == S_SCAN);
    ram_raddr = ring_prev(tail_r);
    if (state_r == S_SCAN) begin
      ram_raddr = ring_prev(scan_p_r);
    end else if ((in_fn == FN_POP_HEAD) || (in_fn == FN_PEEK_HEAD)) begin
      ram_raddr = ring_next(head_r);
    end
  end

  // pointer update, status and next state for an accepted transaction
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    status_nxt = ST_OK;
    state_nxt  = S_FIN;
    unique case (in_fn)
      FN_PUSH_HEAD, FN_PUSH_TAIL: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else if (in_fn == FN_PUSH_HEAD) begin
          head_nxt = ring_prev(head_r);
        end else begin
          tail_nxt = ring_next(tail_r);
        end
      end
      FN_POP_HEAD, FN_POP_TAIL, FN_PEEK_HEAD, FN_PEEK_TAIL: begin
        if (ring_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          state_nxt = S_READ;
          if (in_fn == FN_POP_HEAD) begin
            head_nxt = ring_next(head_r);
          end else if (in_fn == FN_POP_TAIL) begin
            tail_nxt = ring_prev(tail_r);
          end
        end
      end
      FN_CONTAINS: begin
        if (!ring_empty) begin
          state_nxt = S_SCAN;
        end
      end
      FN_CLEAR: begin
        head_nxt = '0;
        tail_nxt = PTR_W'(1);
      end
      default: begin
      end
    endcase
  end

  rbd_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_word),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= PTR_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            word_r       <= in_word;
            res_data_r   <= '0;
            res_found_r  <= 1'b0;
            res_status_r <= status_nxt;
            state_r      <= state_nxt;
            head_r       <= head_nxt;
            tail_r       <= tail_nxt;
            scan_p_r     <= ring_prev(tail_r);
            left_r       <= n_cur;
          end
        end
        S_READ: begin
          res_data_r <= ram_rdata;
          state_r    <= S_FIN;
        end
        S_SCAN: begin
          if (ram_rdata == word_r) begin
            res_found_r <= 1'b1;
            state_r     <= S_FIN;
          end else if (left_r == PTR_W'(1)) begin
            state_r <= S_FIN;
          end else begin
            left_r   <= left_r - 1'b1;
            scan_p_r <= ring_prev(scan_p_r);
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r   <= DATA_W'(res_data_r);
            out_found_r  <= res_found_r;
            out_status_r <= res_status_r;
            out_count_r  <= cnt_ext[COUNT_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_found  = out_found_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule
`default_nettype wire
